[hw/rtl/pfa_pkg.sv]
// Shared types and codes for the page frame allocator.
package pfa_pkg;

  localparam int unsigned INDEX_RANGE = 4096;
  localparam int unsigned BIT_IDX_W   = 6;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OOM         = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_RANGE       = 2'd3
  } pfa_status_e;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } pfa_mode_e;

  typedef struct packed {
    logic                 first_word;
    logic                 last_word;
    logic [BIT_IDX_W-1:0] lo_bit;
    logic [BIT_IDX_W-1:0] hi_bit;
  } search_req_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] bit_idx;
  } search_res_t;

endpackage

[hw/rtl/pfa_map_ram.sv]
// Used-map word memory, one write port and one registered read port.
module pfa_map_ram #(
  parameter int unsigned WORDS     = 64,
  parameter int unsigned WIDTH     = 64,
  parameter int unsigned AW        = 6
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem [WORDS];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/pfa_word_search.sv]
// Masked first-free-bit search over one used-map word.
module pfa_word_search #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  pfa_pkg::search_req_t req_i,
  output pfa_pkg::search_res_t res_o
);

  localparam logic [WORD_BITS-1:0] Ones = {WORD_BITS{1'b1}};

  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] cand;

  assign lo_mask = req_i.first_word ? (Ones << req_i.lo_bit) : Ones;
  assign hi_mask = req_i.last_word ? ~((Ones << req_i.hi_bit) << 1) : Ones;
  assign cand    = ~word_i & lo_mask & hi_mask;

  always_comb begin
    res_o.found   = |cand;
    res_o.bit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        res_o.bit_idx = pfa_pkg::BIT_IDX_W'(b);
      end
    end
  end

endmodule

[hw/rtl/bitmap_page_frame_allocator.sv]
// Top level of the next-fit bitmap page frame allocator.
//
// Requests enter on s_axis: tuser carries the mode (allocate or free),
// tdata the page to free. One result per request leaves on m_axis: tdata
// carries the page and the used-page count, tuser the status code.
// cfg_we_i / cfg_wdata_i write page_count; the user must write it only while
// idle; the block does not enforce this. The used map sits in a
// synchronous word memory, one word per read. A free below the limit passes
// through a map read, a check and write-back, and a hand-off to the result
// register; a free out of range or an allocate with no managed pages goes
// straight to the hand-off. An allocate reads one map word per cycle starting
// at the hint word, wraps once to word zero, and stops at the first word with
// a free page below the limit.
// One request is in flight at a time; s_axis_tready is high only while
// the sequencer is idle.
// After reset a clearing pass writes every map word to zero, one word per
// cycle, with s_axis_tready low.
// The result register holds a finished transaction while m_axis_tready is
// low; a new request is still taken, and its result waits until the
// register empties.
module bitmap_page_frame_allocator #(
  parameter int unsigned MAX_PAGES      = 4096,
  parameter int unsigned SCAN_WORD_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,     // page_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // [11:0] page_number, [15:12] zero
  input  logic [0:0]  s_axis_tuser,    // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [11:0] page_out, [24:12] used_count, [31:25] zero
  output logic [1:0]  m_axis_tuser     // [1:0] status
);

  localparam int unsigned Managed  = (MAX_PAGES < pfa_pkg::INDEX_RANGE) ?
                                     MAX_PAGES : pfa_pkg::INDEX_RANGE;
  localparam int unsigned WordBits = 1 << $clog2(SCAN_WORD_BITS);
  localparam int unsigned Wbl      = $clog2(WordBits);
  localparam int unsigned Words    = (Managed + WordBits - 1) / WordBits;
  localparam int unsigned Aw       = (Words > 1) ? $clog2(Words) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FREE  = 5'b01000,
    S_DONE  = 5'b10000
  } pfa_state_e;

  pfa_state_e state_q, state_d;

  logic [12:0]   cfg_q;
  logic [12:0]   hint_q, hint_d;
  logic [12:0]   count_q, count_d;
  logic [Aw-1:0] clr_addr_q, clr_addr_d;
  logic [Aw-1:0] scan_addr_q, scan_addr_d;
  logic          pass_b_q, pass_b_d;
  logic          issuing_q, issuing_d;
  logic          rv_q, rv_d;
  logic [Aw-1:0] rd_addr_q, rd_addr_d;
  logic          rd_pass_b_q, rd_pass_b_d;
  logic          rd_last_q, rd_last_d;
  logic [11:0]   page_q, page_d;
  logic [11:0]   res_page_q, res_page_d;
  logic [1:0]    res_status_q, res_status_d;
  logic          out_valid_q, out_valid_d;
  logic [11:0]   out_page_q, out_page_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [12:0]   out_count_q, out_count_d;

  logic [12:0]   lim;
  logic [12:0]   lim_m1;
  logic [Aw-1:0] last_word;
  logic [12:0]   hint_word;
  logic          in_accept;
  logic          in_mode;
  logic [11:0]   in_page;
  logic          out_free;

  logic                ram_rd_en;
  logic [Aw-1:0]       ram_rd_addr;
  logic [WordBits-1:0] ram_rd_data;
  logic                ram_wr_en;
  logic [Aw-1:0]       ram_wr_addr;
  logic [WordBits-1:0] ram_wr_data;

  pfa_pkg::search_req_t srch_req;
  pfa_pkg::search_res_t srch_res;
  logic [Wbl-1:0]       found_bit;
  logic [12:0]          found_page;
  logic [Wbl-1:0]       free_bit;

  assign lim       = (cfg_q > 13'(Managed)) ? 13'(Managed) : cfg_q;
  assign lim_m1    = lim - 13'd1;
  assign last_word = Aw'(lim_m1 >> Wbl);
  assign hint_word = hint_q >> Wbl;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_mode       = s_axis_tuser[0];
  assign in_page       = s_axis_tdata[11:0];
  assign out_free      = !out_valid_q || m_axis_tready;

  assign srch_req.first_word = !rd_pass_b_q && (hint_word == 13'(rd_addr_q));
  assign srch_req.last_word  = (rd_addr_q == last_word);
  assign srch_req.lo_bit     = pfa_pkg::BIT_IDX_W'(hint_q[Wbl-1:0]);
  assign srch_req.hi_bit     = pfa_pkg::BIT_IDX_W'(lim_m1[Wbl-1:0]);

  assign found_bit  = srch_res.bit_idx[Wbl-1:0];
  assign found_page = 13'({rd_addr_q, found_bit});
  assign free_bit   = page_q[Wbl-1:0];

  pfa_word_search #(
    .WORD_BITS(WordBits)
  ) u_search (
    .word_i(ram_rd_data),
    .req_i (srch_req),
    .res_o (srch_res)
  );

  pfa_map_ram #(
    .WORDS(Words),
    .WIDTH(WordBits),
    .AW   (Aw)
  ) u_map (
    .clk_i    (clk_i),
    .rd_en_i  (ram_rd_en),
    .rd_addr_i(ram_rd_addr),
    .rd_data_o(ram_rd_data),
    .wr_en_i  (ram_wr_en),
    .wr_addr_i(ram_wr_addr),
    .wr_data_i(ram_wr_data)
  );

  always_comb begin
    state_d      = state_q;
    hint_d       = hint_q;
    count_d      = count_q;
    clr_addr_d   = clr_addr_q;
    scan_addr_d  = scan_addr_q;
    pass_b_d     = pass_b_q;
    issuing_d    = issuing_q;
    rv_d         = 1'b0;
    rd_addr_d    = rd_addr_q;
    rd_pass_b_d  = rd_pass_b_q;
    rd_last_d    = rd_last_q;
    page_d       = page_q;
    res_page_d   = res_page_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_page_d   = out_page_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = scan_addr_q;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = rd_addr_q;
    ram_wr_data  = ram_rd_data;

    case (state_q)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr_q;
        ram_wr_data = '0;
        clr_addr_d  = clr_addr_q + Aw'(1);
        if (clr_addr_q == Aw'(Words - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_mode == pfa_pkg::MODE_FREE) begin
            page_d = in_page;
            if ({1'b0, in_page} >= lim) begin
              res_page_d   = '0;
              res_status_d = pfa_pkg::ST_RANGE;
              state_d      = S_DONE;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = Aw'(in_page >> Wbl);
              rd_addr_d   = Aw'(in_page >> Wbl);
              state_d     = S_FREE;
            end
          end else if (lim == 13'd0) begin
            res_page_d   = '0;
            res_status_d = pfa_pkg::ST_OOM;
            state_d      = S_DONE;
          end else begin
            issuing_d = 1'b1;
            state_d   = S_SCAN;
            if (hint_q < lim) begin
              pass_b_d    = 1'b0;
              scan_addr_d = Aw'(hint_word);
            end else begin
              pass_b_d    = 1'b1;
              scan_addr_d = '0;
            end
          end
        end
      end
      S_SCAN: begin
        if (issuing_q) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = scan_addr_q;
          rv_d        = 1'b1;
          rd_addr_d   = scan_addr_q;
          rd_pass_b_d = pass_b_q;
          rd_last_d   = pass_b_q && (scan_addr_q == last_word);
          if (scan_addr_q == last_word) begin
            if (pass_b_q) begin
              issuing_d = 1'b0;
            end else begin
              pass_b_d    = 1'b1;
              scan_addr_d = '0;
            end
          end else begin
            scan_addr_d = scan_addr_q + Aw'(1);
          end
        end
        if (rv_q) begin
          if (srch_res.found) begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = rd_addr_q;
            ram_wr_data  = ram_rd_data | (WordBits'(1) << found_bit);
            count_d      = count_q + 13'd1;
            hint_d       = found_page + 13'd1;
            res_page_d   = found_page[11:0];
            res_status_d = pfa_pkg::ST_OK;
            issuing_d    = 1'b0;
            rv_d         = 1'b0;
            ram_rd_en    = 1'b0;
            state_d      = S_DONE;
          end else if (rd_last_q) begin
            res_page_d   = '0;
            res_status_d = pfa_pkg::ST_OOM;
            issuing_d    = 1'b0;
            rv_d         = 1'b0;
            ram_rd_en    = 1'b0;
            state_d      = S_DONE;
          end
        end
      end
      S_FREE: begin
        state_d = S_DONE;
        if (ram_rd_data[free_bit]) begin
          ram_wr_en    = 1'b1;
          ram_wr_addr  = rd_addr_q;
          ram_wr_data  = ram_rd_data & ~(WordBits'(1) << free_bit);
          count_d      = count_q - 13'd1;
          res_page_d   = page_q;
          res_status_d = pfa_pkg::ST_OK;
          if ({1'b0, page_q} < hint_q) begin
            hint_d = {1'b0, page_q};
          end
        end else begin
          res_page_d   = '0;
          res_status_d = pfa_pkg::ST_DOUBLE_FREE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_page_d   = res_page_q;
          out_status_d = res_status_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cfg_q       <= 13'd4096;
      hint_q      <= '0;
      count_q     <= '0;
      clr_addr_q  <= '0;
      issuing_q   <= 1'b0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      hint_q      <= hint_d;
      count_q     <= count_d;
      clr_addr_q  <= clr_addr_d;
      issuing_q   <= issuing_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q  <= scan_addr_d;
    pass_b_q     <= pass_b_d;
    rd_addr_q    <= rd_addr_d;
    rd_pass_b_q  <= rd_pass_b_d;
    rd_last_q    <= rd_last_d;
    page_q       <= page_d;
    res_page_q   <= res_page_d;
    res_status_q <= res_status_d;
    out_page_q   <= out_page_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_count_q, out_page_q};
  assign m_axis_tuser  = out_status_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !ram_wr_en)
    else $error("map written outside a request");

  a_rv_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (state_q == S_SCAN))
    else $error("read tag alive outside scan");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 13'(Managed))
    else $error("used count above managed pages");

  a_free_was_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FREE && ram_wr_en) |-> ram_rd_data[free_bit])
    else $error("free wrote back a page that was not used");

  a_ok_alloc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && ram_wr_en) |=> (res_page_q < 12'(Managed - 1)) ||
                                         (res_page_q == 12'(Managed - 1)))
    else $error("allocated page beyond managed range");

endmodule

[tb/sv/tb_bitmap_page_frame_allocator.sv]
// Testbench for the bitmap page frame allocator: frame predictor, stream driver and result checks.
module tb_bitmap_page_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned RAND_ITEMS   = 1500;
  localparam int unsigned RAND_PHASES  = 10;

  typedef struct packed {
    logic [11:0]          page;
    pfa_pkg::pfa_status_e status;
    logic [12:0]          used;
  } frame_reply_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [12:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [11:0] page_number, [15:12] zero
  logic [0:0]  s_axis_tuser  = '0;   // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [11:0] page_out, [24:12] used_count, [31:25] zero
  logic [1:0]  m_axis_tuser;         // [1:0] status

  bit          frame_used [pfa_pkg::INDEX_RANGE];
  logic [12:0] scan_hint     = '0;
  logic [12:0] frames_in_use = '0;
  logic [12:0] page_count_q  = 13'd4096;

  frame_reply_t reply_q[$];

  int unsigned cycle_count     = 0;
  int unsigned error_count     = 0;
  int unsigned items_sent      = 0;
  int unsigned replies_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  bit          no_idle         = 1'b0;
  bit          hold_request    = 1'b0;

  bitmap_page_frame_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, reply_q.size());
      $display("FAIL bitmap_page_frame_allocator");
      $finish;
    end
  end

  function automatic int unsigned managed_pages();
    return (page_count_q > pfa_pkg::INDEX_RANGE) ? pfa_pkg::INDEX_RANGE : int'(page_count_q);
  endfunction

  function automatic frame_reply_t predict_frame_op(pfa_pkg::pfa_mode_e op,
                                                    logic [11:0] page);
    frame_reply_t r;
    int unsigned  lim;
    int           found;
    lim      = managed_pages();
    r.page   = '0;
    r.status = pfa_pkg::ST_OK;
    found    = -1;
    if (op == pfa_pkg::MODE_ALLOC) begin
      for (int p = int'(scan_hint); p < int'(lim) && found < 0; p++)
        if (!frame_used[p]) found = p;
      for (int p = 0; p < int'(lim) && found < 0; p++)
        if (!frame_used[p]) found = p;
      if (found >= 0) begin
        frame_used[found] = 1'b1;
        frames_in_use     = frames_in_use + 13'd1;
        scan_hint         = 13'(found + 1);
        r.page            = 12'(found);
      end else begin
        r.status = pfa_pkg::ST_OOM;
      end
    end else if (page >= lim) begin
      r.status = pfa_pkg::ST_RANGE;
    end else if (!frame_used[page]) begin
      r.status = pfa_pkg::ST_DOUBLE_FREE;
    end else begin
      frame_used[page] = 1'b0;
      frames_in_use    = frames_in_use - 13'd1;
      if (page < scan_hint) scan_hint = {1'b0, page};
      r.page = page;
    end
    r.used = frames_in_use;
    return r;
  endfunction

  function automatic logic [11:0] pick_used_page();
    int unsigned lim;
    int unsigned start;
    int unsigned q;
    lim = managed_pages();
    if (lim == 0) return 12'($urandom());
    start = $urandom_range(0, lim - 1);
    for (int unsigned i = 0; i < lim; i++) begin
      q = (start + i) % lim;
      if (frame_used[q]) return 12'(q);
    end
    return 12'(start);
  endfunction

  function automatic int source_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s at result %0d: got %0d, want %0d", what, replies_checked, got, want);
    error_count++;
  endtask

  task automatic check_reply();
    frame_reply_t want;
    logic [11:0]  got_page;
    logic [12:0]  got_used;
    logic [1:0]   got_status;
    got_page   = m_axis_tdata[11:0];
    got_used   = m_axis_tdata[24:12];
    got_status = m_axis_tuser;
    if (reply_q.size() == 0) begin
      report_mismatch("unexpected result page", got_page, 0);
      return;
    end
    want = reply_q.pop_front();
    replies_checked++;
    status_seen[want.status]++;
    if (got_page !== want.page) report_mismatch("page_out", got_page, want.page);
    if (got_status !== want.status) report_mismatch("status", got_status, want.status);
    if (got_used !== want.used) report_mismatch("used_count", got_used, want.used);
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int r;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_reply();
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idle) begin
          r = $urandom_range(0, 99);
          if (r >= 92) stall_left = $urandom_range(15, 60);
          else if (r >= 70) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  task automatic send_frame_op(input pfa_pkg::pfa_mode_e op, input logic [11:0] page);
    int gap;
    gap = source_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, page};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    reply_q.push_back(predict_frame_op(op, page));
    items_sent++;
  endtask

  task automatic send_random_op(input int alloc_pct);
    int unsigned lim;
    int          r;
    logic [11:0] page;
    lim = managed_pages();
    r   = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < alloc_pct) begin
      send_frame_op(pfa_pkg::MODE_ALLOC, 12'($urandom()));
    end else begin
      if (r < 65) page = pick_used_page();
      else if (r < 85 && lim > 0) page = 12'($urandom_range(0, lim - 1));
      else page = 12'($urandom());
      send_frame_op(pfa_pkg::MODE_FREE, page);
    end
  endtask

  task automatic wait_replies_done();
    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_page_count(input logic [12:0] value);
    wait_replies_done();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    page_count_q  = value;
    cfg_writes++;
  endtask

  task automatic test_directed_cases();
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'hfff);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
    send_frame_op(pfa_pkg::MODE_FREE, 12'd1);
    send_frame_op(pfa_pkg::MODE_FREE, 12'd1);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
    send_frame_op(pfa_pkg::MODE_FREE, 12'hfff);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
    write_page_count(13'd4);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
    send_frame_op(pfa_pkg::MODE_FREE, 12'd4);
    send_frame_op(pfa_pkg::MODE_FREE, 12'hfff);
    write_page_count(13'd0);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
    send_frame_op(pfa_pkg::MODE_FREE, 12'd0);
    write_page_count(13'h1fff);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
    write_page_count(13'd2);
    send_frame_op(pfa_pkg::MODE_FREE, 12'd3);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
    send_frame_op(pfa_pkg::MODE_FREE, 12'd0);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
    write_page_count(13'd4096);
    send_frame_op(pfa_pkg::MODE_FREE, 12'd5);
    send_frame_op(pfa_pkg::MODE_FREE, 12'd2);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
    send_frame_op(pfa_pkg::MODE_ALLOC, 12'd0);
  endtask

  task automatic test_output_hold();
    wait_replies_done();
    no_idle      = 1'b1;
    hold_request = 1'b1;
    repeat (40) send_random_op(60);
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned cap;
    int          alloc_pct;
    for (int ph = 0; ph < int'(RAND_PHASES); ph++) begin
      case (ph % 7)
        0: cap = $urandom_range(2, 16);
        1: cap = 1;
        2: cap = $urandom_range(17, 300);
        3: cap = 4096;
        4: cap = $urandom_range(4097, 8191);
        5: cap = $urandom_range(1, 4095);
        default: cap = 8191;
      endcase
      write_page_count(13'(cap));
      no_idle   = (ph == 4);
      alloc_pct = $urandom_range(55, 85);
      repeat (RAND_ITEMS / (2 * RAND_PHASES)) send_random_op(alloc_pct);
      repeat (RAND_ITEMS / (2 * RAND_PHASES)) send_random_op(100 - alloc_pct);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_idle_pause();
    write_page_count(13'd64);
    repeat (3) begin
      repeat (15) send_random_op(60);
      wait_replies_done();
      repeat ($urandom_range(20, 80)) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_output_hold();
    test_random_traffic();
    test_idle_pause();
    wait_replies_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests, %0d results checked, %0d page_count writes",
             items_sent, replies_checked, cfg_writes);
    $display("status mix: ok %0d, out of memory %0d, double free %0d, out of range %0d",
             status_seen[pfa_pkg::ST_OK], status_seen[pfa_pkg::ST_OOM],
             status_seen[pfa_pkg::ST_DOUBLE_FREE], status_seen[pfa_pkg::ST_RANGE]);
    if (error_count == 0) begin
      $display("PASS bitmap_page_frame_allocator");
    end else begin
      $display("FAIL bitmap_page_frame_allocator");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_map_ram.sv
hw/rtl/pfa_word_search.sv
hw/rtl/bitmap_page_frame_allocator.sv
tb/sv/tb_bitmap_page_frame_allocator.sv
